[hw/rtl/smhb_pkg.sv]
// ----------------------------------------------------------------------------
// smhb_pkg: shared types, constants and functions
// Payload structs, divider control/status and the PJW/ELF byte update.
// ----------------------------------------------------------------------------
package smhb_pkg;

    localparam int HASH_W   = 28;
    localparam int BYTE_W   = 8;
    localparam int BUCKET_W = 20;
    localparam int CNT_W    = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CNT_W-1:0]    DIV_LAST_STEP = CNT_W'(HASH_W - 1);
    localparam logic [BUCKET_W-1:0] BUCKET_RESET  = BUCKET_W'(503);

    // register index taken from paddr[2]
    localparam logic REG_BUCKET_COUNT = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] name_byte;
        logic              last_byte;
    } in_t;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket_index;
        logic [HASH_W-1:0]   full_hash;
    } out_t;

    typedef struct packed {
        logic                start;
        logic [HASH_W-1:0]   dividend;
        logic [BUCKET_W-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [BUCKET_W-1:0] remainder;
    } div_stat_t;

    // shift in one byte, fold top nibble back into bits 7:4, drop it
    function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] b);
        logic [31:0] t;
        t = {h, 4'b0000} + {24'b0, b};
        t = t ^ {24'b0, t[31:28], 4'b0000};
        return t[HASH_W-1:0];
    endfunction

endpackage

[hw/rtl/symbol_name_hash_bucket_unit.sv]
// ----------------------------------------------------------------------------
// symbol_name_hash_bucket_unit: PJW/ELF symbol hash with bucket select
// Running 28-bit hash over name bytes; on the last byte, hash mod bucket_count.
// ----------------------------------------------------------------------------
// Non-last byte: in_ready stays high.
// Last byte: the bit-serial remainder unit runs, then the output register loads;
//   in_ready stays low until that load, longer if out is stalled.
// Output register lets a new name start while a result waits to be taken.
// Reset: running hash 0, bucket_count 503, no result pending.
module symbol_name_hash_bucket_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  smhb_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output smhb_pkg::out_t                out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [smhb_pkg::APB_AW-1:0]   paddr,
    input  logic [smhb_pkg::APB_DW-1:0]   pwdata,
    output logic [smhb_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                            state_reg, state_next;
    logic [smhb_pkg::HASH_W-1:0]     running_hash_reg, running_hash_next;
    logic [smhb_pkg::HASH_W-1:0]     hash_reg, hash_next;
    logic [smhb_pkg::BUCKET_W-1:0]   bucket_count_reg, bucket_count_next;
    logic                            out_valid_reg, out_valid_next;
    smhb_pkg::out_t                  out_reg, out_next;

    logic [smhb_pkg::HASH_W-1:0]     new_hash;
    logic                            in_xfer;
    logic                            out_load;
    smhb_pkg::div_ctrl_t             div_ctrl;
    smhb_pkg::div_stat_t             div_stat;

    smhb_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign new_hash = smhb_pkg::hash_step(running_hash_reg, in_data.name_byte);
    assign out_load = (state_reg == ST_DIV) && div_stat.done && (!out_valid_reg || out_ready);

    assign div_ctrl.start    = in_xfer && in_data.last_byte;
    assign div_ctrl.dividend = new_hash;
    assign div_ctrl.divisor  = bucket_count_reg;

    always_comb
    begin
        state_next        = state_reg;
        running_hash_next = running_hash_reg;
        hash_next         = hash_reg;
        out_valid_next    = out_valid_reg;
        out_next          = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.last_byte)
                    begin
                        running_hash_next = '0;
                        hash_next         = new_hash;
                        state_next        = ST_DIV;
                    end
                    else
                    begin
                        running_hash_next = new_hash;
                    end
                end
            end
            ST_DIV:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (out_load)
        begin
            out_valid_next        = 1'b1;
            out_next.bucket_index = div_stat.remainder;
            out_next.full_hash    = hash_reg;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // APB: single register, decoded on the word index bit
    assign pready = 1'b1;
    always_comb
    begin
        bucket_count_next = bucket_count_reg;
        if (psel && penable && pwrite && (paddr[2] == smhb_pkg::REG_BUCKET_COUNT))
        begin
            bucket_count_next = pwdata[smhb_pkg::BUCKET_W-1:0];
        end
    end
    assign prdata = (paddr[2] == smhb_pkg::REG_BUCKET_COUNT)
                  ? {{(smhb_pkg::APB_DW-smhb_pkg::BUCKET_W){1'b0}}, bucket_count_reg}
                  : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            running_hash_reg <= '0;
            bucket_count_reg <= smhb_pkg::BUCKET_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            running_hash_reg <= running_hash_next;
            bucket_count_reg <= bucket_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_stat.busy)
        else $error("divider busy while accepting bytes");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_data.last_byte) |=> (running_hash_reg == '0))
        else $error("running hash not cleared after last byte");

    a_load_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DIV) && $past(div_stat.done))
        else $error("result loaded without finished remainder");

    a_div_ends_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !div_stat.busy && !div_stat.done) |-> $past(div_ctrl.start))
        else $error("waiting on divider that was never started");

endmodule

[hw/rtl/smhb_divider.sv]
// ----------------------------------------------------------------------------
// smhb_divider: iterative remainder unit
// Restoring division, one dividend bit per cycle through one shared
// subtract/compare. Remainder holds until the next start.
// ----------------------------------------------------------------------------
module smhb_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  smhb_pkg::div_ctrl_t ctrl,
    output smhb_pkg::div_stat_t stat
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [smhb_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [smhb_pkg::HASH_W-1:0]     dividend_reg, dividend_next;
    logic [smhb_pkg::BUCKET_W-1:0]   divisor_reg, divisor_next;
    logic [smhb_pkg::BUCKET_W-1:0]   rem_reg, rem_next;

    logic [smhb_pkg::BUCKET_W:0]     trial;
    logic [smhb_pkg::BUCKET_W:0]     diff;
    logic                            ge;

    assign trial = {rem_reg, dividend_reg[smhb_pkg::HASH_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    // trial < 2*divisor, so the top bit of the difference is the borrow
    assign ge    = !diff[smhb_pkg::BUCKET_W];

    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = done_reg;
        cnt_next      = cnt_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        if (ctrl.start)
        begin
            busy_next     = 1'b1;
            done_next     = 1'b0;
            cnt_next      = '0;
            dividend_next = ctrl.dividend;
            divisor_next  = ctrl.divisor;
            rem_next      = '0;
        end
        else if (busy_reg)
        begin
            rem_next      = ge ? diff[smhb_pkg::BUCKET_W-1:0] : trial[smhb_pkg::BUCKET_W-1:0];
            dividend_next = {dividend_reg[smhb_pkg::HASH_W-2:0], 1'b0};
            cnt_next      = cnt_reg + smhb_pkg::CNT_W'(1);
            if (cnt_reg == smhb_pkg::DIV_LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
    end

    // zero bucket count reads as index 0
    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.remainder = (divisor_reg == '0) ? '0 : rem_reg;

endmodule

[sim/tb_symbol_name_hash_bucket_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_symbol_name_hash_bucket_unit: self-checking bench for the name hash unit
// Streams symbol names byte by byte over valid/ready. A local PJW/ELF hash
// predictor computes the full hash and bucket index for every name, except for
// directed rows with fixed values. Results are compared in order. Bucket count is
// changed over APB between phases, including the value 1, the maximum, zero, and
// a write to an unmapped address. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_symbol_name_hash_bucket_unit;

    localparam int unsigned IDX_BUCKET_COUNT = 0;
    localparam int unsigned IDX_UNMAPPED     = 1;
    localparam int          SETTLE_CYCLES    = 40;
    localparam int          STALL_LIMIT      = 2000;
    localparam int          NUM_PHASES       = 10;
    localparam int          PHASE_ITEMS      = 95;

    typedef struct {
        logic [smhb_pkg::BYTE_W-1:0]   name_byte;
        logic                          last_byte;
        bit                            fixed;
        logic [smhb_pkg::BUCKET_W-1:0] bucket_index;
        logic [smhb_pkg::HASH_W-1:0]   full_hash;
    } name_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    smhb_pkg::in_t                  in_data;
    logic                           out_valid;
    logic                           out_ready;
    smhb_pkg::out_t                 out_data;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [smhb_pkg::APB_AW-1:0]    paddr;
    logic [smhb_pkg::APB_DW-1:0]    pwdata;
    logic [smhb_pkg::APB_DW-1:0]    prdata;
    logic                           pready;

    smhb_pkg::out_t                 due_results[$];
    smhb_pkg::out_t                 rx_exp;
    logic [smhb_pkg::HASH_W-1:0]    model_hash;
    logic [smhb_pkg::BUCKET_W-1:0]  model_buckets;
    int                             errors;
    int                             idle_cycles;
    int                             items_sent;
    bit                             quiet;

    // hash is zero before every typed row, so the values are the byte itself
    name_row_t directed_rows[21] = '{
        '{8'h00, 1'b1, 1'b1, 20'd0,   28'd0},
        '{8'hFF, 1'b1, 1'b1, 20'd255, 28'd255},
        '{8'h01, 1'b1, 1'b1, 20'd1,   28'd1},
        '{8'h41, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'h42, 1'b1, 1'b0, 20'd0,   28'd0},
        '{8'hFF, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'hFF, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'hFF, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'hFF, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'hFF, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'hFF, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'hFF, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'hFF, 1'b1, 1'b0, 20'd0,   28'd0},
        '{8'h80, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'h00, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'h7F, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'h01, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'hFE, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'h10, 1'b0, 1'b0, 20'd0,   28'd0},
        '{8'h20, 1'b1, 1'b0, 20'd0,   28'd0},
        '{8'hF6, 1'b1, 1'b1, 20'd246, 28'd246}
    };

    symbol_name_hash_bucket_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // shift in a byte, fold the top nibble down into bits 7:4 and clear it
    function automatic logic [smhb_pkg::HASH_W-1:0] pjw_update(
        input logic [smhb_pkg::HASH_W-1:0] h,
        input logic [smhb_pkg::BYTE_W-1:0] b);
        logic [31:0] acc;
        logic [31:0] top;
        acc = {h, 4'b0000} + {24'd0, b};
        top = acc & 32'hF000_0000;
        if (top != 32'd0)
        begin
            acc = acc ^ (top >> 24);
            acc = acc & ~top;
        end
        return acc[smhb_pkg::HASH_W-1:0];
    endfunction

    function automatic logic [smhb_pkg::BUCKET_W-1:0] bucket_of(
        input logic [smhb_pkg::HASH_W-1:0]   h,
        input logic [smhb_pkg::BUCKET_W-1:0] n);
        logic [31:0] rem;
        if (n == '0)
            return '0;
        rem = {4'd0, h} % {12'd0, n};
        return rem[smhb_pkg::BUCKET_W-1:0];
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [smhb_pkg::BYTE_W-1:0] b, input logic lst,
                             input bit fixed,
                             input logic [smhb_pkg::BUCKET_W-1:0] fixed_idx,
                             input logic [smhb_pkg::HASH_W-1:0] fixed_hash);
        logic [smhb_pkg::HASH_W-1:0] nxt;
        smhb_pkg::out_t              e;
        if (!quiet)
        begin
            while ($urandom_range(99) < 6)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        in_data.name_byte = b;
        in_data.last_byte = lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        nxt = pjw_update(model_hash, b);
        if (lst)
        begin
            e.full_hash    = fixed ? fixed_hash : nxt;
            e.bucket_index = fixed ? fixed_idx : bucket_of(nxt, model_buckets);
            due_results.push_back(e);
            model_hash = '0;
        end
        else
        begin
            model_hash = nxt;
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic reg_write(input int unsigned idx,
                             input logic [smhb_pkg::APB_DW-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = smhb_pkg::APB_AW'(idx * 4);
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (idx == IDX_BUCKET_COUNT)
            model_buckets = data[smhb_pkg::BUCKET_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_bucket_reg();
        logic [smhb_pkg::APB_DW-1:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = smhb_pkg::APB_AW'(IDX_BUCKET_COUNT * 4);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        got = prdata;
        if (got !== {{(smhb_pkg::APB_DW-smhb_pkg::BUCKET_W){1'b0}}, model_buckets})
        begin
            $display("%0t bucket_count read: expected %0d, actual %0d",
                     $time, model_buckets, got);
            errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_name();
        int unsigned len;
        int unsigned sel;
        logic [smhb_pkg::BYTE_W-1:0] b;
        sel = $urandom_range(99);
        if (sel < 80)
            len = $urandom_range(1, 12);
        else if (sel < 95)
            len = $urandom_range(13, 40);
        else
            len = 1;
        for (int unsigned k = 0; k < len; k++)
        begin
            sel = $urandom_range(99);
            if (sel < 15)
                b = 8'h00;
            else if (sel < 30)
                b = 8'hFF;
            else
                b = 8'($urandom);
            send_byte(b, (k == len - 1), 1'b0, '0, '0);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual idx %0d hash %h",
                         $time, out_data.bucket_index, out_data.full_hash);
                errors++;
            end
            else
            begin
                rx_exp = due_results.pop_front();
                if (out_data.bucket_index !== rx_exp.bucket_index)
                begin
                    $display("%0t bucket_index: expected %0d, actual %0d",
                             $time, rx_exp.bucket_index, out_data.bucket_index);
                    errors++;
                end
                if (out_data.full_hash !== rx_exp.full_hash)
                begin
                    $display("%0t full_hash: expected %h, actual %h",
                             $time, rx_exp.full_hash, out_data.full_hash);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL symbol_name_hash_bucket_unit");
            $finish;
        end
    end

    initial
    begin
        logic [smhb_pkg::BUCKET_W-1:0] cfg_vals[NUM_PHASES];
        logic [smhb_pkg::APB_DW-1:0]   wdata;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        errors        = 0;
        idle_cycles   = 0;
        items_sent    = 0;
        quiet         = 1'b0;
        model_hash    = '0;
        model_buckets = smhb_pkg::BUCKET_RESET;
        cfg_vals = '{20'd1, 20'd1048575, 20'd0, 20'd2, 20'd65521, 20'd503,
                     20'd1048573, 20'd0, 20'd0, 20'd0};
        cfg_vals[7] = smhb_pkg::BUCKET_W'($urandom_range(3, 1021));
        cfg_vals[8] = smhb_pkg::BUCKET_W'($urandom_range(1, 1048575));
        cfg_vals[9] = smhb_pkg::BUCKET_W'($urandom_range(1, 4095));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        check_bucket_reg();
        foreach (directed_rows[i])
            send_byte(directed_rows[i].name_byte, directed_rows[i].last_byte,
                      directed_rows[i].fixed, directed_rows[i].bucket_index,
                      directed_rows[i].full_hash);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            // unmapped address: must leave bucket_count alone
            if (p == 4)
                reg_write(IDX_UNMAPPED, 32'h0000_0007);
            wdata = {12'd0, cfg_vals[p]};
            if (p % 2 == 1)
                wdata[smhb_pkg::APB_DW-1:smhb_pkg::BUCKET_W] = 12'($urandom);
            reg_write(IDX_BUCKET_COUNT, wdata);
            check_bucket_reg();
            quiet = (p == 5);
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
            begin
                send_name();
                // in phase 2, hold off mid-phase until the result queue is empty
                if (p == 2 && items_sent >= PHASE_ITEMS / 2 && items_sent < PHASE_ITEMS / 2 + 41)
                begin
                    wait_drained();
                    items_sent = PHASE_ITEMS / 2 + 41;
                end
            end
        end

        wait_drained();
        if (errors == 0)
            $display("PASS symbol_name_hash_bucket_unit");
        else
            $display("FAIL symbol_name_hash_bucket_unit");
        $finish;
    end

endmodule
